// ===== hdl/sacnru_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacnru_pkg
// Shared constants, register indexes and the configuration bundle of the
// set-associative NRU cache.
// ----------------------------------------------------------------------------
package sacnru_pkg;

  localparam int ADDR_BITS_DEF     = 32;
  localparam int MAX_SETS_LOG2_DEF = 8;
  localparam int MAX_WAYS_DEF      = 8;
  localparam int QUEUE_DEPTH       = 2;

  // configuration register indexes
  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_SETS_LOG2   = 2'd1;
  localparam logic [1:0] REG_WAYS_USED   = 2'd2;
  localparam logic [1:0] REG_INDEX_MASK  = 2'd3;

  // register values after reset
  localparam logic [4:0]  RST_OFFSET_BITS = 5'd2;
  localparam logic [3:0]  RST_SETS_LOG2   = 4'd4;
  localparam logic [3:0]  RST_WAYS_USED   = 4'd4;
  localparam logic [31:0] RST_INDEX_MASK  = 32'd60;

  typedef struct packed {
    logic [4:0]  offset_bits;
    logic [3:0]  sets_log2;
    logic [3:0]  ways_used;
    logic [31:0] index_mask;
  } cfg_t;

endpackage

// ===== hdl/sacnru_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacnru_queue
// Short FIFO between the lookup front end and the set update back end.
// ----------------------------------------------------------------------------
module sacnru_queue
  import sacnru_pkg::*;
#(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [DATA_W-1:0] store_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = store_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/sacnru_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacnru_front
// Accepts access addresses and forms the tag and set index. The positions of
// the index bits are worked out from the mask by a one-bit-a-cycle scan.
// ----------------------------------------------------------------------------
module sacnru_front
  import sacnru_pkg::*;
#(
  parameter int ADDR_BITS     = ADDR_BITS_DEF,
  parameter int MAX_SETS_LOG2 = MAX_SETS_LOG2_DEF,
  parameter int IDX_W         = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 mask_wr,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          in_address,
  output logic                 push_valid,
  input  logic                 push_ready,
  output logic [ADDR_BITS-1:0] push_tag,
  output logic [IDX_W-1:0]     push_idx
);

  localparam int AB_W = $clog2(ADDR_BITS);
  localparam int SB_W = $clog2(ADDR_BITS + 1);

  logic [SB_W-1:0]      scan_b_r;
  logic [SB_W-1:0]      k_r;
  logic [IDX_W-1:0]     en_r;
  logic [AB_W-1:0]      pos_r [IDX_W];
  logic                 scan_busy;
  logic                 mask_bit;
  logic [ADDR_BITS-1:0] addr_lim;

  assign scan_busy = (scan_b_r != SB_W'(ADDR_BITS));
  assign mask_bit  = cfg.index_mask[scan_b_r[AB_W-1:0]];

  // rescan after reset and after every mask write
  always_ff @(posedge clk) begin
    if (!rst_n || mask_wr) begin
      scan_b_r <= '0;
      k_r      <= '0;
      en_r     <= '0;
    end else if (scan_busy) begin
      if (mask_bit) begin
        for (int j = 0; j < IDX_W; j++) begin
          if (k_r == SB_W'(j) && j < MAX_SETS_LOG2) begin
            pos_r[j] <= scan_b_r[AB_W-1:0];
            en_r[j]  <= 1'b1;
          end
        end
        k_r <= k_r + 1'b1;
      end
      scan_b_r <= scan_b_r + 1'b1;
    end
  end

  assign addr_lim = in_address[ADDR_BITS-1:0];

  always_comb begin
    if ({1'b0, cfg.offset_bits} >= 6'(ADDR_BITS)) begin
      push_tag = '0;
    end else begin
      push_tag = addr_lim >> cfg.offset_bits;
    end
    for (int j = 0; j < IDX_W; j++) begin
      push_idx[j] = en_r[j] && (4'(j) < cfg.sets_log2) && addr_lim[pos_r[j]];
    end
  end

  assign in_ready   = !scan_busy && push_ready;
  assign push_valid = in_valid && !scan_busy;

endmodule

// ===== hdl/sacnru_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacnru_back
// Set store and NRU update: reads the set row, compares the ways, writes the
// row back and registers the result. Clears the store after reset.
// ----------------------------------------------------------------------------
module sacnru_back
  import sacnru_pkg::*;
#(
  parameter int ADDR_BITS     = ADDR_BITS_DEF,
  parameter int MAX_SETS_LOG2 = MAX_SETS_LOG2_DEF,
  parameter int MAX_WAYS      = MAX_WAYS_DEF,
  parameter int IDX_W         = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic [ADDR_BITS-1:0] q_tag,
  input  logic [IDX_W-1:0]     q_idx,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic [2:0]           out_way
);

  localparam int ROWS  = 2 ** MAX_SETS_LOG2;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(ROWS - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;

  typedef struct packed {
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag;
    logic [MAX_WAYS-1:0]                vld;
    logic [MAX_WAYS-1:0]                nru;
  } row_t;

  row_t                 mem [ROWS];
  row_t                 rdata_r;
  row_t                 new_row, clr_row, wdata;
  logic [1:0]           state_r, state_nxt;
  logic [IDX_W-1:0]     clr_row_r;
  logic [IDX_W-1:0]     idx_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r;
  logic [2:0]           out_way_r;
  logic                 pop, out_load, mem_we;
  logic [IDX_W-1:0]     waddr;
  logic [4:0]           wu, ways_sat;
  logic [MAX_WAYS-1:0]  in_use, hit_vec, nru_vec;
  logic [WAY_W-1:0]     hit_way, nru_way, way_sel;
  logic                 any_hit;

  assign pop      = (state_r == S_IDLE) && q_valid;
  assign q_ready  = (state_r == S_IDLE);
  assign out_load = (state_r == S_EVAL) && (!out_valid_r || out_ready);

  always_comb begin
    wu = {1'b0, cfg.ways_used};
    if (wu == '0) begin
      ways_sat = 5'd1;
    end else if (wu > 5'(MAX_WAYS)) begin
      ways_sat = 5'(MAX_WAYS);
    end else begin
      ways_sat = wu;
    end
  end

  always_comb begin
    hit_way = '0;
    nru_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]  = 5'(w) < ways_sat;
      hit_vec[w] = in_use[w] && rdata_r.vld[w] && (rdata_r.tag[w] == tag_r);
      nru_vec[w] = in_use[w] && rdata_r.nru[w];
    end
    // lowest way wins
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (nru_vec[w]) begin
        nru_way = WAY_W'(w);
      end
    end
    any_hit = |hit_vec;
    new_row = rdata_r;
    if (any_hit) begin
      way_sel              = hit_way;
      new_row.nru[hit_way] = 1'b0;
    end else if (|nru_vec) begin
      way_sel              = nru_way;
      new_row.nru[nru_way] = 1'b0;
      new_row.vld[nru_way] = 1'b1;
      new_row.tag[nru_way] = tag_r;
    end else begin
      // no candidate: re-arm the set and fill way 0
      way_sel = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (in_use[w]) begin
          new_row.nru[w] = 1'b1;
        end
      end
      new_row.nru[0] = 1'b0;
      new_row.vld[0] = 1'b1;
      new_row.tag[0] = tag_r;
    end
  end

  always_comb begin
    clr_row     = '0;
    clr_row.nru = '1;
    mem_we      = (state_r == S_CLEAR) || out_load;
    waddr       = (state_r == S_CLEAR) ? clr_row_r : idx_r;
    wdata       = (state_r == S_CLEAR) ? clr_row : new_row;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_row_r == LAST_ROW) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_CLEAR) begin
        clr_row_r <= clr_row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tag_r <= q_tag;
      idx_r <= q_idx;
    end
    if (out_load) begin
      out_hit_r <= any_hit;
      out_way_r <= 3'(way_sel);
    end
  end

  // set store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (pop) begin
      rdata_r <= mem[q_idx];
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_way   = out_way_r;

  a_no_pop_while_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !pop)
    else $error("queue popped during clearing pass");

  a_way_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (5'(way_sel) < ways_sat))
    else $error("selected way beyond ways in use");

  a_eval_returns_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (state_r == S_IDLE) && out_valid_r)
    else $error("result not presented after set update");

  a_chosen_not_nru : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !new_row.nru[way_sel] && new_row.vld[way_sel])
    else $error("chosen way left marked not recently used or invalid");

endmodule

// ===== hdl/set_assoc_cache_nru.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_nru
// Set-associative cache lookup with NRU replacement: one hit/way result per
// access address.
// An accepted address waits in the queue, its set row is read as it leaves
// the queue and written back in S_EVAL, and out_valid rises once the result
// register is free. The back end pops no new entry until the row of the last
// is written back. Reset: a clearing pass over the 2**MAX_SETS_LOG2 rows
// (256 by default) empties the store; in_ready is low after reset and after
// each index_mask write while the index bit positions are rescanned.
// ----------------------------------------------------------------------------
module set_assoc_cache_nru
  import sacnru_pkg::*;
#(
  parameter int ADDR_BITS     = ADDR_BITS_DEF,
  parameter int MAX_SETS_LOG2 = MAX_SETS_LOG2_DEF,
  parameter int MAX_WAYS      = MAX_WAYS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [2:0]  out_way
);

  localparam int IDX_W = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1;
  localparam int ENT_W = ADDR_BITS + IDX_W;

  cfg_t                 cfg_r;
  logic                 mask_wr;
  logic                 f_valid, f_ready;
  logic [ADDR_BITS-1:0] f_tag;
  logic [IDX_W-1:0]     f_idx;
  logic                 q_valid, q_ready;
  logic [ENT_W-1:0]     q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_bits <= RST_OFFSET_BITS;
      cfg_r.sets_log2   <= RST_SETS_LOG2;
      cfg_r.ways_used   <= RST_WAYS_USED;
      cfg_r.index_mask  <= RST_INDEX_MASK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_BITS: cfg_r.offset_bits <= cfg_wdata[4:0];
        REG_SETS_LOG2:   cfg_r.sets_log2   <= cfg_wdata[3:0];
        REG_WAYS_USED:   cfg_r.ways_used   <= cfg_wdata[3:0];
        REG_INDEX_MASK:  cfg_r.index_mask  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign mask_wr = cfg_we && (cfg_index == REG_INDEX_MASK);

  sacnru_front #(
    .ADDR_BITS    (ADDR_BITS),
    .MAX_SETS_LOG2(MAX_SETS_LOG2),
    .IDX_W        (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mask_wr   (mask_wr),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_address(in_address),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_tag  (f_tag),
    .push_idx  (f_idx)
  );

  sacnru_queue #(
    .DATA_W(ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data ({f_tag, f_idx}),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  sacnru_back #(
    .ADDR_BITS    (ADDR_BITS),
    .MAX_SETS_LOG2(MAX_SETS_LOG2),
    .MAX_WAYS     (MAX_WAYS),
    .IDX_W        (IDX_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_tag    (q_data[ENT_W-1:IDX_W]),
    .q_idx    (q_data[IDX_W-1:0]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_hit  (out_hit),
    .out_way  (out_way)
  );

endmodule
